### rtl/core/shpd_pkg.sv
// shared types, constants and helpers for the super-hires pixel decoder
package shpd_pkg;

  localparam int PALETTE_COUNT_DEF = 16;
  localparam int ENTRIES           = 16;
  localparam int ENTRY_W           = 4;
  localparam int COLOR_W           = 12;
  localparam int WORD_W            = 16;
  localparam int PADDR_W           = 5;
  localparam int PDATA_W           = 32;

  typedef enum logic [1:0] {
    MODE_PLAIN = 2'd0,
    MODE_FILL  = 2'd1,
    MODE_HIRES = 2'd2
  } line_mode_t;

  typedef enum logic [2:0] {
    REG_MONO_0 = 3'd0,
    REG_MONO_1 = 3'd1,
    REG_MONO_2 = 3'd2,
    REG_MONO_3 = 3'd3,
    REG_EXTEND = 3'd4
  } reg_idx_t;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_COLOR = 2'd1,
    OP_MONO  = 2'd2
  } op_t;

  typedef struct packed {
    logic         action;
    logic         line_start;
    logic [1:0]   line_mode;
    logic [3:0]   palette_select;
    logic [7:0]   pixel_byte;
    logic [7:0]   palette_address;
    logic [11:0]  palette_value;
  } in_t;

  typedef struct packed {
    logic [15:0]  pixel_first;
    logic [15:0]  pixel_second;
    logic         last;
  } out_t;

  typedef struct packed {
    op_t          op;
    logic         sel_ok;
    logic [7:0]   addr_hi;
    logic [7:0]   addr_lo;
    logic [11:0]  data;
  } entry_t;

  typedef struct packed {
    logic [3:0][15:0] mono;
    logic [15:0]      ext;
  } cfg_t;

  function automatic logic [WORD_W-1:0] rgb333(input logic [COLOR_W-1:0] c,
                                                input logic [WORD_W-1:0] ext);
    return {7'b0, c[11:9], c[7:5], c[3:1]} | ext;
  endfunction

endpackage

### rtl/core/shpd_front.sv
// front end: accepts beats, resolves fill indices and classifies work
module shpd_front #(
  parameter int PALETTE_COUNT = shpd_pkg::PALETTE_COUNT_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  shpd_pkg::in_t   in_data,
  input  logic            q_full,
  output logic            q_push,
  output shpd_pkg::entry_t q_entry
);
  import shpd_pkg::*;

  localparam logic [8:0] DEPTH_W = 9'(PALETTE_COUNT * ENTRIES);
  localparam logic [4:0] COUNT_W = 5'(PALETTE_COUNT);

  logic [ENTRY_W-1:0] fill_r, fill_nxt;
  logic [ENTRY_W-1:0] base_idx, hi_idx, lo_idx;
  logic               accept, sel_ok, addr_ok, hires;

  always_comb begin
    in_ready = !q_full;
    accept   = in_valid && in_ready;
    sel_ok   = {1'b0, in_data.palette_select} < COUNT_W;
    addr_ok  = {1'b0, in_data.palette_address} < DEPTH_W;
    hires    = in_data.line_mode[1];
    base_idx = in_data.line_start ? '0 : fill_r;
    hi_idx   = in_data.pixel_byte[7:4];
    lo_idx   = in_data.pixel_byte[3:0];
    if (in_data.line_mode == MODE_FILL) begin
      if (hi_idx == '0) begin
        hi_idx = base_idx;
      end
      if (lo_idx == '0) begin
        lo_idx = hi_idx;
      end
    end
    fill_nxt = fill_r;
    if (accept && !in_data.action) begin
      fill_nxt = hires ? base_idx : lo_idx;
    end

    q_push          = accept && (!in_data.action || addr_ok);
    q_entry.sel_ok  = sel_ok;
    if (in_data.action) begin
      q_entry.op      = OP_WRITE;
      q_entry.addr_hi = in_data.palette_address;
      q_entry.addr_lo = in_data.palette_address;
      q_entry.data    = in_data.palette_value;
    end else if (hires) begin
      q_entry.op      = OP_MONO;
      q_entry.addr_hi = '0;
      q_entry.addr_lo = '0;
      q_entry.data    = {4'b0, in_data.pixel_byte};
    end else begin
      q_entry.op      = OP_COLOR;
      q_entry.addr_hi = sel_ok ? {in_data.palette_select, hi_idx} : '0;
      q_entry.addr_lo = sel_ok ? {in_data.palette_select, lo_idx} : '0;
      q_entry.data    = {4'b0, in_data.pixel_byte};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else begin
      fill_r <= fill_nxt;
    end
  end

endmodule

### rtl/core/shpd_queue.sv
// two-entry queue between front and back
module shpd_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  shpd_pkg::entry_t push_entry,
  output logic             full,
  input  logic             pop,
  output logic             pop_valid,
  output shpd_pkg::entry_t pop_entry
);
  import shpd_pkg::*;

  entry_t     slot_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r, count_nxt;

  always_comb begin
    full      = count_r == 2'd2;
    pop_valid = count_r != 2'd0;
    pop_entry = slot_r[rd_ptr_r];
    count_nxt = count_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

### rtl/core/shpd_back.sv
// back end: palette store, lookup stage and output register
module shpd_back #(
  parameter int PALETTE_COUNT = shpd_pkg::PALETTE_COUNT_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_valid,
  input  shpd_pkg::entry_t q_entry,
  output logic             q_pop,
  input  shpd_pkg::cfg_t   cfg,
  output logic             out_valid,
  input  logic             out_ready,
  output shpd_pkg::out_t   out_data
);
  import shpd_pkg::*;

  localparam int DEPTH = PALETTE_COUNT * ENTRIES;
  localparam int AW    = $clog2(DEPTH);

  logic [COLOR_W-1:0] mem [DEPTH];
  entry_t             s1_r;
  logic               s1_valid_r, s1_valid_nxt;
  logic               s1_phase_r, s1_phase_nxt;
  logic [COLOR_W-1:0] rd_hi_r, rd_lo_r, c_hi, c_lo;
  out_t               out_r, beat;
  logic               out_valid_r;
  logic               out_free, s1_fire, s1_done;
  logic [1:0]         dot0, dot1;

  always_comb begin
    out_free = !out_valid_r || out_ready;
    s1_fire  = s1_valid_r && out_free;
    s1_done  = s1_fire && (s1_r.op != OP_MONO || s1_phase_r);
    q_pop    = q_valid && (!s1_valid_r || s1_done);

    c_hi = s1_r.sel_ok ? rd_hi_r : '0;
    c_lo = s1_r.sel_ok ? rd_lo_r : '0;
    dot0 = s1_phase_r ? s1_r.data[3:2] : s1_r.data[7:6];
    dot1 = s1_phase_r ? s1_r.data[1:0] : s1_r.data[5:4];
    case (s1_r.op)
      OP_MONO: begin
        beat.pixel_first  = cfg.mono[dot0];
        beat.pixel_second = cfg.mono[dot1];
        beat.last         = s1_phase_r;
      end
      default: begin
        beat.pixel_first  = rgb333(c_hi, cfg.ext);
        beat.pixel_second = rgb333(c_lo, cfg.ext);
        beat.last         = 1'b1;
      end
    endcase

    s1_valid_nxt = s1_valid_r;
    s1_phase_nxt = s1_phase_r;
    if (s1_done) begin
      s1_valid_nxt = 1'b0;
      s1_phase_nxt = 1'b0;
    end else if (s1_fire) begin
      s1_phase_nxt = 1'b1;
    end
    if (q_pop && q_entry.op != OP_WRITE) begin
      s1_valid_nxt = 1'b1;
      s1_phase_nxt = 1'b0;
    end

    out_valid = out_valid_r;
    out_data  = out_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s1_phase_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      s1_phase_r <= s1_phase_nxt;
      if (s1_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      s1_r <= q_entry;
    end
    if (q_pop && q_entry.op == OP_WRITE) begin
      mem[q_entry.addr_hi[AW-1:0]] <= q_entry.data;
    end
    if (q_pop && q_entry.op != OP_WRITE) begin
      rd_hi_r <= mem[q_entry.addr_hi[AW-1:0]];
      rd_lo_r <= mem[q_entry.addr_lo[AW-1:0]];
    end
    if (s1_fire) begin
      out_r <= beat;
    end
  end

endmodule

### rtl/core/super_hires_scanline_pixel_decode_core.sv
// top level of the super-hires pixel decoder with its register file
// A palette write yields no result beat, a 320-mode screen byte one and a
// 640-mode byte two, which leave one after the other through the single
// output register; the input side keeps accepting while a two-entry queue
// has room. After its byte is accepted, a result passes the queue, the
// palette store read and the output register, in that order. The palette
// store has one write port and two read ports, so both nibbles of a byte are
// looked up in the same cycle. Store entries are undefined until written.
// Registers: 0..3 are the 640-mode dot pair words and 4 the extend mask, at
// byte addresses 0, 4, 8, 12 and 16.
module super_hires_scanline_pixel_decode_core #(
  parameter int PALETTE_COUNT = shpd_pkg::PALETTE_COUNT_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  shpd_pkg::in_t                in_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output shpd_pkg::out_t               out_data,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [shpd_pkg::PADDR_W-1:0] paddr,
  input  logic [shpd_pkg::PDATA_W-1:0] pwdata,
  output logic [shpd_pkg::PDATA_W-1:0] prdata,
  output logic                         pready
);
  import shpd_pkg::*;

  logic [3:0][WORD_W-1:0] mono_r;
  logic [WORD_W-1:0]      ext_r;
  logic [2:0]             reg_idx;
  logic                   wr_en;
  cfg_t                   cfg;
  logic                   q_full, q_push, q_pop, q_valid;
  entry_t                 push_entry, pop_entry;

  always_comb begin
    pready   = 1'b1;
    reg_idx  = paddr[4:2];
    wr_en    = psel && penable && pwrite;
    cfg.mono = mono_r;
    cfg.ext  = ext_r;
    case (reg_idx)
      REG_MONO_0: prdata = {16'b0, mono_r[0]};
      REG_MONO_1: prdata = {16'b0, mono_r[1]};
      REG_MONO_2: prdata = {16'b0, mono_r[2]};
      REG_MONO_3: prdata = {16'b0, mono_r[3]};
      REG_EXTEND: prdata = {16'b0, ext_r};
      default:    prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mono_r <= '0;
      ext_r  <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        REG_MONO_0: mono_r[0] <= pwdata[15:0];
        REG_MONO_1: mono_r[1] <= pwdata[15:0];
        REG_MONO_2: mono_r[2] <= pwdata[15:0];
        REG_MONO_3: mono_r[3] <= pwdata[15:0];
        REG_EXTEND: ext_r     <= pwdata[15:0];
        default:    ;
      endcase
    end
  end

  shpd_front #(.PALETTE_COUNT(PALETTE_COUNT)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_entry  (push_entry)
  );

  shpd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (q_pop),
    .pop_valid  (q_valid),
    .pop_entry  (pop_entry)
  );

  shpd_back #(.PALETTE_COUNT(PALETTE_COUNT)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_entry   (pop_entry),
    .q_pop     (q_pop),
    .cfg       (cfg),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

### rtl/core/shpd_checker.sv
// port-level checks for the super-hires pixel decoder and their bind
module shpd_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         out_valid,
  input logic                         out_ready,
  input shpd_pkg::out_t               out_data,
  input logic                         psel,
  input logic                         penable,
  input logic                         pwrite,
  input logic [shpd_pkg::PADDR_W-1:0] paddr,
  input logic [shpd_pkg::PDATA_W-1:0] pwdata,
  input logic [shpd_pkg::PDATA_W-1:0] prdata
);
  import shpd_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  a_pair_follows: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_data.last |=> out_valid && out_data.last)
    else $error("second 640-mode beat did not follow");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_reg_readback: assert property (@(posedge clk) disable iff (!rst_n)
    psel && penable && pwrite && paddr[4:2] == REG_EXTEND
    |=> paddr[4:2] != REG_EXTEND || prdata[15:0] == $past(pwdata[15:0]))
    else $error("extend mask readback mismatch");

endmodule

bind super_hires_scanline_pixel_decode_core shpd_checker u_shpd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data),
  .psel      (psel),
  .penable   (penable),
  .pwrite    (pwrite),
  .paddr     (paddr),
  .pwdata    (pwdata),
  .prdata    (prdata)
);
